/* design/rbb_pkg.sv */
package rbb_pkg;

  localparam int MAX_RADIUS = 15;
  localparam int MAX_WIDTH  = 1024;
  localparam int HIST_DEPTH = 2 * MAX_RADIUS + 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int RAD_CFG_W  = 4;
  localparam int WID_W      = 11;
  localparam int OUT_COL_W  = 10;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int PTR_W = $clog2(HIST_DEPTH);
  localparam int CNT_W = $clog2(2 * MAX_RADIUS + 2);
  localparam int SUM_W = 8 + CNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = CFG_IDX_W'(1);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t             pix;
    logic [COL_W-1:0]   col;
    logic [PTR_W-1:0]   ptr;
    logic [RAD_W-1:0]   rad;
    logic               last;
  } cmd_t;

endpackage

/* design/rbb_front.sv */
module rbb_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  output logic                           push_valid,
  input  logic                           push_ready,
  output rbb_pkg::cmd_t                  push_data,
  output logic                           row_clear
);
  import rbb_pkg::*;

  logic [RAD_CFG_W-1:0] radius;
  logic [WID_W-1:0]     row_width;
  logic [COL_W-1:0]     column;
  logic [PTR_W-1:0]     ptr;

  logic [WID_W-1:0] w_eff;
  logic [WID_W-1:0] half;
  logic [WID_W-1:0] r_lim;
  logic [WID_W-1:0] r_fin;
  logic             is_last;
  logic             take;
  logic             cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && cfg_ready &&
                     (cfg_index == CFG_RADIUS || cfg_index == CFG_ROW_WIDTH);
  assign row_clear = cfg_hit;

  always_comb begin
    if (row_width == '0) begin
      w_eff = WID_W'(1);
    end else if (row_width > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = row_width;
    end
    half  = (w_eff - WID_W'(1)) >> 1;
    r_lim = (WID_W'(radius) > WID_W'(MAX_RADIUS)) ? WID_W'(MAX_RADIUS) : WID_W'(radius);
    r_fin = (r_lim > half) ? half : r_lim;
  end

  assign is_last = (WID_W'(column) == w_eff - WID_W'(1));

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign take       = in_valid && push_ready;

  always_comb begin
    push_data.pix.red   = in_red;
    push_data.pix.green = in_green;
    push_data.pix.blue  = in_blue;
    push_data.col       = column;
    push_data.ptr       = ptr;
    push_data.rad       = r_fin[RAD_W-1:0];
    push_data.last      = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= RAD_CFG_W'(1);
      row_width <= WID_W'(320);
      column    <= '0;
      ptr       <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == CFG_RADIUS) begin
        radius <= cfg_data[RAD_CFG_W-1:0];
      end else begin
        row_width <= cfg_data[WID_W-1:0];
      end
      column <= '0;
      ptr    <= '0;
    end else if (take) begin
      if (is_last) begin
        column <= '0;
        ptr    <= '0;
      end else begin
        column <= column + COL_W'(1);
        ptr    <= (ptr == PTR_W'(HIST_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
      end
    end
  end

endmodule

/* design/rbb_queue.sv */
module rbb_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  rbb_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output rbb_pkg::cmd_t pop_data
);
  import rbb_pkg::*;

  cmd_t       ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = ent[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* design/rbb_div.sv */
module rbb_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rbb_pkg::SUM_W-1:0] num_red,
  input  logic [rbb_pkg::SUM_W-1:0] num_green,
  input  logic [rbb_pkg::SUM_W-1:0] num_blue,
  input  logic [rbb_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output rbb_pkg::pixel_t           quot
);
  import rbb_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [2:0][SUM_W-1:0] quo;
  logic [2:0][CNT_W:0]   rem;
  logic [2:0][SUM_W-1:0] quo_next;
  logic [2:0][CNT_W:0]   rem_next;
  logic [CNT_W-1:0]      dvs;
  logic [STEP_W-1:0]     step;
  logic                  busy;

  // one quotient bit per cycle on all three channels
  always_comb begin
    logic [CNT_W:0] trial;
    for (int i = 0; i < 3; i++) begin
      trial = {rem[i][CNT_W-1:0], quo[i][SUM_W-1]};
      if (trial >= {1'b0, dvs}) begin
        rem_next[i] = trial - {1'b0, dvs};
        quo_next[i] = {quo[i][SUM_W-2:0], 1'b1};
      end else begin
        rem_next[i] = trial;
        quo_next[i] = {quo[i][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo[0] <= num_red;
      quo[1] <= num_green;
      quo[2] <= num_blue;
      rem    <= '0;
      dvs    <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot.red   = quo[0][7:0];
  assign quot.green = quo[1][7:0];
  assign quot.blue  = quo[2][7:0];

endmodule

/* design/rbb_back.sv */
module rbb_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          row_clear,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  rbb_pkg::cmd_t                 pop_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic [rbb_pkg::OUT_COL_W-1:0] out_column,
  output logic                          last_of_run
);
  import rbb_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_DROP = 6'b000100,
    S_LOAD = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t st;
  cmd_t   cmd;
  pixel_t hist [HIST_DEPTH];
  pixel_t rdata;
  pixel_t quot;

  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] cnt;
  logic [COL_W-1:0] ocol;
  logic             flush;
  logic [SUM_W-1:0] sum_red;
  logic [SUM_W-1:0] sum_green;
  logic [SUM_W-1:0] sum_blue;

  logic [PTR_W:0]   rd_tmp;
  logic [PTR_W-1:0] rd_idx;
  logic [CNT_W-1:0] win_in;
  logic [CNT_W-1:0] win_main;
  logic             pop;
  logic             div_done;
  logic             out_free;
  logic             this_last;
  logic             more_flush;

  assign pop_ready = (st == S_IDLE);
  assign pop       = pop_valid && pop_ready;
  assign out_free  = !out_valid || out_ready;

  // window of the popped item and of the held command: 2r+1
  assign win_in   = CNT_W'({pop_data.rad, 1'b1});
  assign win_main = CNT_W'({cmd.rad, 1'b1});

  // history slot of column (col - k), wrapped
  always_comb begin
    rd_tmp = (PTR_W + 1)'(cmd.ptr) + (PTR_W + 1)'(HIST_DEPTH) - (PTR_W + 1)'(k);
    if (rd_tmp >= (PTR_W + 1)'(HIST_DEPTH)) begin
      rd_tmp = rd_tmp - (PTR_W + 1)'(HIST_DEPTH);
    end
    rd_idx = rd_tmp[PTR_W-1:0];
  end

  always_comb begin
    if (flush) begin
      this_last  = (k == CNT_W'(cmd.rad) + CNT_W'(1));
      more_flush = !this_last;
    end else begin
      this_last  = !(cmd.last && cmd.rad != '0);
      more_flush = !this_last;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hist[pop_data.ptr] <= pop_data.pix;
    end
    rdata <= hist[rd_idx];
  end

  rbb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (st == S_LOAD),
    .num_red   (sum_red),
    .num_green (sum_green),
    .num_blue  (sum_blue),
    .divisor   (cnt),
    .done      (div_done),
    .quot      (quot)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      flush     <= 1'b0;
      k         <= '0;
      cnt       <= '0;
      ocol      <= '0;
      sum_red   <= '0;
      sum_green <= '0;
      sum_blue  <= '0;
    end else if (row_clear) begin
      sum_red   <= '0;
      sum_green <= '0;
      sum_blue  <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (pop) begin
            sum_red   <= sum_red + SUM_W'(pop_data.pix.red);
            sum_green <= sum_green + SUM_W'(pop_data.pix.green);
            sum_blue  <= sum_blue + SUM_W'(pop_data.pix.blue);
            flush     <= 1'b0;
            k         <= win_in;
            cnt       <= CNT_W'(pop_data.col) + CNT_W'(1);
            ocol      <= pop_data.col - COL_W'(pop_data.rad);
            priority if (pop_data.col >= COL_W'(win_in)) begin
              st <= S_RD;
            end else if (pop_data.col >= COL_W'(pop_data.rad)) begin
              st <= S_LOAD;
            end else begin
              st <= S_IDLE;
            end
          end
        end
        S_RD: begin
          st <= S_DROP;
        end
        S_DROP: begin
          sum_red   <= sum_red - SUM_W'(rdata.red);
          sum_green <= sum_green - SUM_W'(rdata.green);
          sum_blue  <= sum_blue - SUM_W'(rdata.blue);
          cnt       <= k;
          st        <= S_LOAD;
        end
        S_LOAD: begin
          st <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            st <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (more_flush) begin
              flush <= 1'b1;
              k     <= flush ? k - CNT_W'(1) : win_main - CNT_W'(1);
              ocol  <= ocol + COL_W'(1);
              st    <= S_RD;
            end else begin
              if (cmd.last) begin
                sum_red   <= '0;
                sum_green <= '0;
                sum_blue  <= '0;
              end
              st <= S_IDLE;
            end
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_OUT && out_free) begin
      out_red     <= quot.red;
      out_green   <= quot.green;
      out_blue    <= quot.blue;
      out_column  <= OUT_COL_W'(ocol);
      last_of_run <= this_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* design/row_box_blur_top.sv */
// Horizontal box blur over a raster stream of RGB pixels, one pixel per input transfer.
// Each result is the per-channel truncated mean of the pixels of the same row within
// radius of its column; the window is clipped at the row edges and the divisor shrinks
// with it. Results lag the input by radius pixels, the last pixel of a row flushes the
// remaining radius+1 results, and last_of_run marks the final result of each input.
// The radius is clamped to (row_width-1)/2 and to 15; a row_width of 0 acts as 1 and
// one above 1024 as 1024. Writing either register restarts the row at column 0. Every
// result passes through one shared three-channel divider that yields one quotient bit
// per cycle. A pixel whose result needs no pixel dropped from the window passes the
// load, divide and output states; one that drops a pixel passes the history read and
// drop states first, as does each further result of a row-end flush. A pixel that
// makes no result is only summed and stored. A two-entry queue lets pixels be taken
// while the back end is busy, and an output register holds a result until it is taken.
module row_box_blur_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [rbb_pkg::OUT_COL_W-1:0]  out_column,
  output logic                           last_of_run
);
  import rbb_pkg::*;

  cmd_t push_data;
  cmd_t pop_data;
  logic push_valid;
  logic push_ready;
  logic pop_valid;
  logic pop_ready;
  logic row_clear;

  rbb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .row_clear  (row_clear)
  );

  rbb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rbb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .row_clear   (row_clear),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_column  (out_column),
    .last_of_run (last_of_run)
  );

endmodule

/* bench/row_box_blur_checker.sv */
`timescale 1ns / 1ps

module row_box_blur_checker
  import rbb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            out_red,
  input  logic [7:0]            out_green,
  input  logic [7:0]            out_blue,
  input  logic [OUT_COL_W-1:0]  out_column,
  input  logic                  last_of_run,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [OUT_COL_W-1:0] column;
    logic                 last;
  } blurred_pixel_t;

  blurred_pixel_t blurred_q[$];

  logic [RAD_CFG_W-1:0] radius_reg;
  logic [WID_W-1:0]     width_reg;
  int                   sum_red, sum_green, sum_blue;
  logic [23:0]          row_hist [HIST_DEPTH];
  int                   col_count;
  int                   mismatches;

  assign errors = mismatches;

  function automatic void clear_row();
    sum_red   = 0;
    sum_green = 0;
    sum_blue  = 0;
    col_count = 0;
  endfunction

  function automatic void drop_column(int col);
    logic [23:0] p;
    p = row_hist[col % HIST_DEPTH];
    sum_red   -= p[23:16];
    sum_green -= p[15:8];
    sum_blue  -= p[7:0];
  endfunction

  function automatic void push_mean(int col, int count, logic last);
    blurred_pixel_t e;
    e.red    = 8'(sum_red / count);
    e.green  = 8'(sum_green / count);
    e.blue   = 8'(sum_blue / count);
    e.column = OUT_COL_W'(col);
    e.last   = last;
    blurred_q.push_back(e);
  endfunction

  function automatic void predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int w, rad, c, lo, o;
    logic row_end;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    rad = radius_reg;
    if (rad > MAX_RADIUS) rad = MAX_RADIUS;
    if (rad > (w - 1) / 2) rad = (w - 1) / 2;
    c = col_count;
    if (c >= w) begin
      clear_row();
      c = 0;
    end
    row_hist[c % HIST_DEPTH] = {r, g, b};
    sum_red   += r;
    sum_green += g;
    sum_blue  += b;
    if (c >= 2 * rad + 1) drop_column(c - 2 * rad - 1);
    row_end = (c == w - 1);
    if (c >= rad) begin
      lo = (c >= 2 * rad) ? c - 2 * rad : 0;
      push_mean(c - rad, c - lo + 1, !(row_end && rad > 0));
    end
    if (row_end) begin
      // flush the tail of the row
      for (o = c - rad + 1; o <= w - 1; o++) begin
        if (o >= rad + 1) drop_column(o - rad - 1);
        lo = (o >= rad) ? o - rad : 0;
        push_mean(o, w - lo, o == w - 1);
      end
      clear_row();
    end else begin
      col_count = c + 1;
    end
  endfunction

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  initial mismatches = 0;

  always @(posedge clk) begin
    blurred_pixel_t e;
    if (rst) begin
      radius_reg = RAD_CFG_W'(1);
      width_reg  = WID_W'(320);
      clear_row();
      foreach (row_hist[i]) row_hist[i] = '0;
      blurred_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (blurred_q.size() == 0) begin
          $error("out_column: unexpected result transfer, column %0d", out_column);
          mismatches++;
        end else begin
          e = blurred_q.pop_front();
          check_field("out_red", e.red, out_red);
          check_field("out_green", e.green, out_green);
          check_field("out_blue", e.blue, out_blue);
          check_field("out_column", e.column, out_column);
          check_field("last_of_run", e.last, last_of_run);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RADIUS: begin
            radius_reg = cfg_data[RAD_CFG_W-1:0];
            clear_row();
          end
          CFG_ROW_WIDTH: begin
            width_reg = cfg_data;
            clear_row();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_pixel(in_red, in_green, in_blue);
    end
    pending <= blurred_q.size();
  end

endmodule

/* bench/row_box_blur_top_tb.sv */
`timescale 1ns / 1ps

module row_box_blur_top_tb;
  import rbb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_3 = CFG_IDX_W'(3);
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 280;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_red = '0;
  logic [7:0]            in_green = '0;
  logic [7:0]            in_blue = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_red, out_green, out_blue;
  logic [OUT_COL_W-1:0]  out_column;
  logic                  last_of_run;

  int errors, pending;
  int quiet_cycles = 0;
  int hold_req = 0, hold_seen = 0, hold_left = 0;
  bit tx_idle_on = 1'b1, rx_idle_on = 1'b1;

  always #2 clk = ~clk;

  row_box_blur_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_column(out_column), .last_of_run(last_of_run)
  );

  row_box_blur_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_column(out_column), .last_of_run(last_of_run),
    .errors(errors), .pending(pending)
  );

  // receiver: random back-pressure plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(rx_idle_on && $urandom_range(99) < 36);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** row_box_blur_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return 8'hFF;
      1: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while (tx_idle_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pixel(rand_channel(), rand_channel(), rand_channel());
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    settle(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_radius(input int rad);
    write_reg(CFG_RADIUS, {7'($urandom), 4'(rad)});
  endtask

  initial begin
    int sent, rad, w, weff, rows;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: row in progress, ignored index, then abandoned row
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hAA);
    write_reg(CFG_UNMAPPED_3, 11'h7FF);
    send_pixel(8'h55, 8'hFF, 8'h01);
    write_reg(CFG_UNMAPPED_2, 11'h000);
    write_reg(CFG_ROW_WIDTH, 11'd1);
    write_reg(CFG_RADIUS, 11'h7FF);
    send_random(2);
    write_reg(CFG_ROW_WIDTH, 11'd0);
    send_random(1);
    write_reg(CFG_ROW_WIDTH, 11'd2);
    write_radius(1);
    send_random(2);
    write_reg(CFG_ROW_WIDTH, 11'd3);
    write_radius(15);
    send_random(3);
    write_reg(CFG_ROW_WIDTH, 11'd5);
    write_radius(2);
    repeat (5) send_pixel(8'hFF, 8'hFF, 8'hFF);
    write_reg(CFG_ROW_WIDTH, 11'd4);
    write_radius(1);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_random(2);

    // widest row, widest window, all white then random, dropped part way
    write_reg(CFG_ROW_WIDTH, 11'h7FF);
    write_radius(15);
    repeat (40) send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_random(60);

    // no idling, then a long receiver hold-off while pixels keep coming
    write_reg(CFG_ROW_WIDTH, 11'd40);
    write_radius(3);
    tx_idle_on <= 1'b0;
    rx_idle_on <= 1'b0;
    send_random(40);
    hold_req <= hold_req + 1;
    send_random(40);
    tx_idle_on <= 1'b1;
    rx_idle_on <= 1'b1;

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0: rad = 0;
        1: rad = 15;
        default: rad = $urandom_range(0, 15);
      endcase
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = $urandom_range(1, 3);
        default: w = $urandom_range(1, 48);
      endcase
      weff = (w == 0) ? 1 : w;
      if ($urandom_range(0, 1)) begin
        write_radius(rad);
        write_reg(CFG_ROW_WIDTH, 11'(w));
      end else begin
        write_reg(CFG_ROW_WIDTH, 11'(w));
        write_radius(rad);
      end
      rows = $urandom_range(1, 4);
      repeat (rows) begin
        send_random(weff);
        sent += weff;
      end
      case ($urandom_range(0, 5))
        0: begin
          // partial row, dropped by the next register write
          rows = $urandom_range(0, weff - 1);
          send_random(rows);
          sent += rows;
        end
        1: begin
          rows = $urandom_range(0, weff - 1);
          send_random(rows);
          settle(0);
          send_random(weff - rows);
          sent += weff;
        end
        2: begin
          rows = $urandom_range(0, weff - 1);
          send_random(rows);
          write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_2 : CFG_UNMAPPED_3, 11'($urandom));
          send_random(weff - rows);
          sent += weff;
        end
        default: ;
      endcase
    end

    settle(SETTLE_CYCLES);
    if (errors == 0) begin
      $display("** row_box_blur_top: PASSED **");
    end else begin
      $display("** row_box_blur_top: FAILED **");
    end
    $finish;
  end

endmodule
